FILE: hdl/stif_pkg.sv
// Package for the segment table insert/flush block.
// Holds sizes, field widths and shared types; no dependencies.
package stif_pkg;

    localparam int WAYS         = 8;
    localparam int GROUPS       = 32;
    localparam int RECENT_DEPTH = 8;
    localparam int SEG_WIDTH    = 36;
    localparam int NSLOTS       = GROUPS * WAYS;
    localparam int WAY_W        = $clog2(WAYS);
    localparam int GRP_W        = $clog2(GROUPS);
    localparam int SLOT_W       = $clog2(NSLOTS);
    localparam int CAND_N       = 2 * WAYS;
    localparam int CAND_W       = $clog2(CAND_N);
    localparam int RCNT_W       = $clog2(RECENT_DEPTH + 2);
    localparam int RIDX_W       = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int ENTRY_W      = 2 * SEG_WIDTH;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef logic [SEG_WIDTH-1:0] t_seg;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CAND_W-1:0]    t_cand;

    typedef struct packed {
        logic  mode;
        t_seg  seg_esid;
        t_seg  seg_vsid;
    } t_in;

    typedef struct packed {
        logic [7:0] slot_index;
        logic       evicted;
        t_seg       evicted_esid;
    } t_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic  take_in;      // latch the incoming transaction
        logic  cand_clr;     // restart candidate counter
        logic  cand_inc;     // advance candidate counter
        logic  use_rr;       // candidate = rr pointer + counter
        logic  mem_rd;       // read entry at current address
        logic  probe_free;   // check valid of candidate
        logic  victim_chk;   // check read esid against kernel base
        logic  pick_first;   // default victim: pointer start slot
        logic  do_write;     // write entry at chosen slot
        logic  rec_push;     // remember slot in recent list
        logic  fl_rec;       // flush: clear one recent slot
        logic  fl_all;       // flush: sweep whole table
        logic  fl_done;      // flush finished
        logic  out_load;     // load result register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic  mode;
        logic  free_hit;     // candidate slot is free
        logic  victim_hit;   // read esid differs from kernel base
        logic  cand_last;    // counter at last candidate
        logic  rec_last;     // recent walk at last entry
        logic  rec_empty;
        logic  rec_over;
        logic  sweep_last;
        logic  out_busy;
    } t_sts;

endpackage

FILE: hdl/stif_if.sv
// Valid/ready channel interface carrying one payload type.
// No dependencies; the payload type is a parameter.
interface stif_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/stif_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module stif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule

FILE: hdl/stif_dp.sv
// Datapath: entry memory, valid bits, round-robin pointer, recent list and
// result register. Depends on stif_pkg and stif_ram.
module stif_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stif_pkg::t_cmd   i_cmd,
    output stif_pkg::t_sts   o_sts,
    input  stif_pkg::t_seg   i_kbase,
    input  stif_pkg::t_in    i_in,
    output stif_pkg::t_out   o_out,
    output logic             o_out_valid,
    input  logic             i_out_ready
);
    import stif_pkg::*;

    logic [NSLOTS-1:0]  r_valid;
    t_in                r_in;
    t_cand              r_cnt;
    logic [CAND_W-1:0]  r_rr;
    t_cand              r_pick;
    logic               r_evict;
    t_slot              r_slot;
    t_slot              r_sweep;
    logic [RCNT_W-1:0]  r_rcnt;
    logic [RIDX_W-1:0]  r_ridx;
    t_slot              r_recent [RECENT_DEPTH];
    t_out               r_out;
    logic               r_ovalid;

    logic [GRP_W-1:0]   pg;
    logic [GRP_W-1:0]   sg;
    t_cand              cand;
    t_slot              cslot;
    t_slot              addr;
    logic [ENTRY_W-1:0] rdata;
    t_seg               rd_esid;
    logic               user_ins;

    // Candidate slot from primary/secondary group and candidate number.
    assign pg   = r_in.seg_esid[GRP_W-1:0];
    assign sg   = GRP_W'(GROUPS - 1) - pg;
    assign cand = i_cmd.use_rr ? CAND_W'(r_rr + r_cnt) : r_cnt;
    always_comb begin
        if (cand < CAND_W'(WAYS)) begin
            cslot = SLOT_W'(pg * WAYS) + SLOT_W'(cand);
        end else begin
            cslot = SLOT_W'(sg * WAYS) + SLOT_W'(cand - CAND_W'(WAYS));
        end
    end

    // Memory address: sweep, chosen slot or candidate.
    always_comb begin
        if (i_cmd.fl_all) begin
            addr = r_sweep;
        end else if (i_cmd.do_write) begin
            addr = r_slot;
        end else begin
            addr = cslot;
        end
    end

    stif_ram #(.WIDTH(ENTRY_W), .DEPTH(NSLOTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.do_write),
        .i_addr  (addr),
        .i_wdata ({r_in.seg_esid, r_in.seg_vsid}),
        .i_re    (i_cmd.mem_rd),
        .o_rdata (rdata)
    );
    assign rd_esid  = rdata[ENTRY_W-1 -: SEG_WIDTH];
    assign user_ins = r_in.seg_esid < i_kbase;

    // Status back to the controller.
    always_comb begin
        o_sts.mode       = r_in.mode;
        o_sts.free_hit   = !r_valid[cslot];
        o_sts.victim_hit = rd_esid != i_kbase;
        o_sts.cand_last  = r_cnt == CAND_W'(CAND_N - 1);
        o_sts.rec_last   = RCNT_W'(r_ridx) + RCNT_W'(1) >= r_rcnt;
        o_sts.rec_empty  = r_rcnt == '0;
        o_sts.rec_over   = r_rcnt > RCNT_W'(RECENT_DEPTH);
        o_sts.sweep_last = r_sweep == SLOT_W'(NSLOTS - 1);
        o_sts.out_busy   = r_ovalid && !i_out_ready;
    end

    // Input latch and counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_in <= i_in;
        end
        if (i_cmd.cand_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cand_inc) begin
            r_cnt <= r_cnt + CAND_W'(1);
        end
        // Free slot found during the probe.
        if (i_cmd.probe_free) begin
            r_slot <= cslot;
        end
        // Default victim is the slot at the pointer start.
        if (i_cmd.pick_first) begin
            r_slot <= cslot;
            r_pick <= cand;
        end
        // The read esid belongs to the current candidate, read in S_VRD or S_VRD2.
        if (i_cmd.victim_chk) begin
            r_slot <= cslot;
            r_pick <= cand;
        end
    end

    // Control registers: valid bits, pointer, recent list, result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rr     <= '0;
            r_rcnt   <= '0;
            r_ridx   <= '0;
            r_sweep  <= SLOT_W'(1);
            r_ovalid <= 1'b0;
            r_evict  <= 1'b0;
        end else begin
            if (i_cmd.take_in) begin
                r_ridx  <= '0;
                r_sweep <= SLOT_W'(1);
                r_evict <= 1'b0;
            end
            if (i_cmd.pick_first) begin
                r_evict <= 1'b1;
            end
            if (i_cmd.do_write) begin
                r_valid[r_slot] <= 1'b1;
                if (r_evict) begin
                    r_rr <= r_pick + CAND_W'(1);
                end
            end
            if (i_cmd.rec_push && user_ins) begin
                if (r_rcnt < RCNT_W'(RECENT_DEPTH)) begin
                    r_recent[r_rcnt[RIDX_W-1:0]] <= r_slot;
                    r_rcnt <= r_rcnt + RCNT_W'(1);
                end else begin
                    r_rcnt <= RCNT_W'(RECENT_DEPTH + 1);
                end
            end
            if (i_cmd.fl_rec) begin
                r_valid[r_recent[r_ridx]] <= 1'b0;
                r_ridx <= r_ridx + RIDX_W'(1);
            end
            // Sweep: data read last cycle belongs to r_sweep - 1.
            if (i_cmd.fl_all) begin
                r_sweep <= r_sweep + SLOT_W'(1);
                if (r_sweep != SLOT_W'(1) && r_valid[r_sweep - SLOT_W'(1)]
                        && rd_esid < i_kbase) begin
                    r_valid[r_sweep - SLOT_W'(1)] <= 1'b0;
                end
            end
            if (i_cmd.fl_done) begin
                r_rcnt <= '0;
                // Last swept entry, read on the final sweep cycle.
                if (o_sts.rec_over && r_valid[NSLOTS-1] && rd_esid < i_kbase) begin
                    r_valid[NSLOTS-1] <= 1'b0;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.slot_index   <= (r_in.mode == MODE_FLUSH) ? 8'd0 : 8'(r_slot);
            r_out.evicted      <= (r_in.mode == MODE_INSERT) && r_evict;
            r_out.evicted_esid <= ((r_in.mode == MODE_INSERT) && r_evict) ?
                                  rd_esid : '0;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_ovalid;
endmodule

FILE: hdl/stif_ctrl.sv
// Controller state machine sequencing probe, victim walk, write and flush.
// Depends on stif_pkg.
module stif_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  stif_pkg::t_sts i_sts,
    output stif_pkg::t_cmd o_cmd
);
    import stif_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROBE = 4'd1;
    localparam logic [3:0] S_VRD   = 4'd2;
    localparam logic [3:0] S_VCHK  = 4'd3;
    localparam logic [3:0] S_RDV   = 4'd4;
    localparam logic [3:0] S_WR    = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_FREC  = 4'd7;
    localparam logic [3:0] S_FALL  = 4'd8;
    localparam logic [3:0] S_FEND  = 4'd9;
    localparam logic [3:0] S_VDONE = 4'd10;
    localparam logic [3:0] S_VRD2  = 4'd11;
    localparam logic [3:0] S_RDV2  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in  = 1'b1;
                    o_cmd.cand_clr = 1'b1;
                    n_state        = S_PROBE;
                end
            end
            // Walk candidates for the first free slot; a flush picks its path here.
            S_PROBE: begin
                if (i_sts.mode == MODE_FLUSH) begin
                    if (i_sts.rec_over) begin
                        o_cmd.fl_all = 1'b1;
                        o_cmd.mem_rd = 1'b1;
                        n_state      = S_FALL;
                    end else if (i_sts.rec_empty) begin
                        n_state = S_FEND;
                    end else begin
                        n_state = S_FREC;
                    end
                end else if (i_sts.free_hit) begin
                    o_cmd.probe_free = 1'b1;
                    n_state          = S_WR;
                end else if (i_sts.cand_last) begin
                    o_cmd.cand_clr = 1'b1;
                    n_state        = S_VRD;
                end else begin
                    o_cmd.cand_inc = 1'b1;
                end
            end
            // Default victim, and first read of the pointer walk.
            S_VRD: begin
                o_cmd.use_rr     = 1'b1;
                o_cmd.pick_first = 1'b1;
                o_cmd.mem_rd     = 1'b1;
                n_state          = S_VCHK;
            end
            S_VCHK: begin
                o_cmd.use_rr = 1'b1;
                if (i_sts.victim_hit) begin
                    o_cmd.victim_chk = 1'b1;
                    n_state          = S_RDV;
                end else if (i_sts.cand_last) begin
                    n_state = S_VDONE;
                end else begin
                    o_cmd.cand_inc = 1'b1;
                    n_state        = S_VRD2;
                end
            end
            S_VDONE: begin
                o_cmd.cand_clr = 1'b1;
                n_state        = S_RDV2;
            end
            S_VRD2: begin
                o_cmd.use_rr = 1'b1;
                o_cmd.mem_rd = 1'b1;
                n_state      = S_VCHK;
            end
            // Reread the victim so its esid is on the read port.
            S_RDV: begin
                o_cmd.use_rr = 1'b1;
                o_cmd.mem_rd = 1'b1;
                n_state      = S_WR;
            end
            S_RDV2: begin
                o_cmd.use_rr = 1'b1;
                o_cmd.mem_rd = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.do_write = 1'b1;
                    o_cmd.rec_push = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            S_FREC: begin
                o_cmd.fl_rec = 1'b1;
                if (i_sts.rec_last) begin
                    n_state = S_FEND;
                end
            end
            S_FALL: begin
                o_cmd.fl_all = 1'b1;
                o_cmd.mem_rd = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                if (!i_sts.out_busy) begin
                    o_cmd.fl_done  = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: hdl/segment_table_insert_flush.sv
// Top level of the hashed segment table with insert and flush.
// Depends on stif_pkg, stif_if, stif_ctrl and stif_dp.
//
// One transaction at a time. An insert probes the candidates in order until a
// free slot is found; when all 16 candidates are full, a round-robin victim
// walk reads the single-port entry memory. A flush clears each remembered slot,
// or sweeps the table through the memory port when the list overflowed. The
// result register lets a finished result wait; a stalled receiver adds its wait.
module segment_table_insert_flush (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  stif_pkg::t_seg    i_cfg_wdata,
    stif_if.sink              in_ch,
    stif_if.source            out_ch
);
    import stif_pkg::*;

    t_seg r_kbase;
    t_cmd cmd;
    t_sts sts;

    // Kernel base register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbase <= 36'hC_0000_0000;
        end else if (i_cfg_we) begin
            r_kbase <= i_cfg_wdata;
        end
    end

    stif_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    stif_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kbase     (r_kbase),
        .i_in        (in_ch.data),
        .o_out       (out_ch.data),
        .o_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready)
    );
endmodule

FILE: dv/segment_table_insert_flush_tb.sv
// Testbench for the hashed segment table with insert and flush.
// Depends on stif_pkg, stif_if and segment_table_insert_flush.
`timescale 1ns / 1ps

module segment_table_insert_flush_tb;
    import stif_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    t_seg i_cfg_wdata = '0;

    stif_if #(.T(t_in))  in_ch ();
    stif_if #(.T(t_out)) out_ch ();

    segment_table_insert_flush uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the table state.
    t_seg        kernel_base;
    logic        tbl_valid [NSLOTS];
    t_seg        tbl_esid [NSLOTS];
    int unsigned rr_ptr;
    int unsigned recent_list [RECENT_DEPTH];
    int unsigned recent_cnt;

    t_out expected_results [$];
    int   error_count = 0;
    bit   idle_enable = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int unsigned cand_slot(int unsigned pg, int unsigned sg,
                                              int unsigned c);
        return (c < WAYS) ? pg * WAYS + c : sg * WAYS + (c - WAYS);
    endfunction

    // Predict the result of one transaction and update the shadow state.
    function automatic t_out predict_table_op(t_in item);
        t_out r;
        int unsigned pg, sg, slot, start, pick;
        bit placed;
        r = '0;
        slot = 0;
        placed = 1'b0;
        if (item.mode == MODE_FLUSH) begin
            if (recent_cnt <= RECENT_DEPTH) begin
                for (int i = 0; i < recent_cnt; i++) tbl_valid[recent_list[i]] = 1'b0;
            end else begin
                for (int s = 1; s < NSLOTS; s++)
                    if (tbl_valid[s] && tbl_esid[s] < kernel_base) tbl_valid[s] = 1'b0;
            end
            recent_cnt = 0;
            return r;
        end
        pg = int'(item.seg_esid[GRP_W-1:0]);
        sg = GROUPS - 1 - pg;
        for (int c = 0; c < CAND_N && !placed; c++) begin
            if (!tbl_valid[cand_slot(pg, sg, c)]) begin
                slot = cand_slot(pg, sg, c);
                placed = 1'b1;
            end
        end
        if (!placed) begin
            start = rr_ptr % CAND_N;
            pick = start;
            for (int i = 0; i < CAND_N; i++) begin
                if (tbl_esid[cand_slot(pg, sg, (start + i) % CAND_N)] != kernel_base) begin
                    pick = (start + i) % CAND_N;
                    break;
                end
            end
            slot = cand_slot(pg, sg, pick);
            rr_ptr = (pick + 1) % CAND_N;
            r.evicted = 1'b1;
            r.evicted_esid = tbl_esid[slot];
        end
        tbl_valid[slot] = 1'b1;
        tbl_esid[slot] = item.seg_esid;
        if (item.seg_esid < kernel_base) begin
            if (recent_cnt < RECENT_DEPTH) begin
                recent_list[recent_cnt] = slot;
                recent_cnt++;
            end else begin
                recent_cnt = RECENT_DEPTH + 1;
            end
        end
        r.slot_index = slot[7:0];
        return r;
    endfunction

    // Send one transaction, with an optional random gap before it. Valid stays
    // high after acceptance so that the next transaction can follow directly.
    task automatic send_item(input t_in item);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= item;
        expected_results.push_back(predict_table_op(item));
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_insert(input t_seg esid, input t_seg vsid);
        t_in item;
        item.mode = MODE_INSERT;
        item.seg_esid = esid;
        item.seg_vsid = vsid;
        send_item(item);
    endtask

    task automatic send_flush();
        t_in item;
        item.mode = MODE_FLUSH;
        item.seg_esid = t_seg'({$urandom, $urandom});
        item.seg_vsid = t_seg'({$urandom, $urandom});
        send_item(item);
    endtask

    // Stop driving and wait until every result has come back.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_kernel_base(input t_seg value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        kernel_base = value;
    endtask

    // Esid that hashes to a chosen group, above or below the kernel base.
    function automatic t_seg esid_for_group(int unsigned grp, bit kernel);
        t_seg e;
        e = t_seg'({$urandom, $urandom});
        e[GRP_W-1:0] = grp[GRP_W-1:0];
        if (kernel && e < kernel_base) e = kernel_base | t_seg'(grp);
        if (!kernel && e >= kernel_base) e = t_seg'(grp);
        return e;
    endfunction

    // Check each result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no expectation");
            end else begin
                t_out e;
                e = expected_results.pop_front();
                if (out_ch.data.slot_index !== e.slot_index)
                    report_mismatch($sformatf("slot_index %0d, expected %0d",
                                              out_ch.data.slot_index, e.slot_index));
                if (out_ch.data.evicted !== e.evicted)
                    report_mismatch($sformatf("evicted %0b, expected %0b",
                                              out_ch.data.evicted, e.evicted));
                if (out_ch.data.evicted_esid !== e.evicted_esid)
                    report_mismatch($sformatf("evicted_esid %h, expected %h",
                                              out_ch.data.evicted_esid, e.evicted_esid));
            end
        end
    end

    // Receiver stalls in random bursts.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_enable && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Directed: both groups filled, eviction, kernel skip, flushes.
    task automatic test_directed();
        send_insert('0, '0);
        send_insert('1, '1);
        for (int i = 0; i < CAND_N + 2; i++)
            send_insert(esid_for_group(3, i[0]), t_seg'({$urandom, $urandom}));
        send_flush();
        send_insert(esid_for_group(5, 0), '1);
        send_flush();
        send_flush();
        wait_idle();
    endtask

    // Every candidate holds the kernel base, so the pointer slot goes anyway.
    task automatic test_all_kernel();
        write_kernel_base(t_seg'(36'h000000007));
        for (int i = 0; i < CAND_N + 3; i++) send_insert(kernel_base, t_seg'($urandom));
        wait_idle();
        write_kernel_base('0);
        for (int i = 0; i < 20; i++)
            send_insert(t_seg'({$urandom, $urandom}), t_seg'($urandom));
        send_flush();
        wait_idle();
        write_kernel_base('1);
        for (int i = 0; i < 20; i++) send_insert(esid_for_group(9, 0), t_seg'($urandom));
        send_flush();
        wait_idle();
    endtask

    // Random mix focused on few groups so evictions and overflow happen often.
    task automatic test_random(input int count, input t_seg base);
        write_kernel_base(base);
        for (int i = 0; i < count; i++) begin
            int unsigned k;
            k = $urandom_range(0, 99);
            if (k < 8) send_flush();
            else if (k < 20) send_insert(t_seg'({$urandom, $urandom}),
                                         t_seg'({$urandom, $urandom}));
            else send_insert(esid_for_group($urandom_range(0, 3), $urandom_range(0, 3) == 0),
                             t_seg'({$urandom, $urandom}));
        end
        wait_idle();
    endtask

    initial begin
        in_ch.valid <= 1'b0;
        in_ch.data <= '0;
        kernel_base = t_seg'(36'hC00000000);
        rr_ptr = 0;
        recent_cnt = 0;
        for (int s = 0; s < NSLOTS; s++) begin
            tbl_valid[s] = 1'b0;
            tbl_esid[s] = '0;
        end
        for (int i = 0; i < RECENT_DEPTH; i++) recent_list[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_all_kernel();
        test_random(500, t_seg'(36'hC00000000));
        test_random(400, t_seg'({$urandom, $urandom}));
        idle_enable = 1'b0;
        test_random(500, t_seg'(36'h800000000));
        if (error_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/stif_pkg.sv
hdl/stif_if.sv
hdl/stif_ram.sv
hdl/stif_dp.sv
hdl/stif_ctrl.sv
hdl/segment_table_insert_flush.sv
dv/segment_table_insert_flush_tb.sv
